// File: design/nlsc_pkg.sv
// ----------------------------------------------------------------------------
// nlsc_pkg
// Shared types and helpers for the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
`default_nettype none

package nlsc_pkg;

	localparam int unsigned NalTypeMask = 5'h1f;
	localparam logic [4:0]  NalTypeIdr  = 5'd5;
	localparam int unsigned BurstMax    = 4;

	// Status codes on the final result of a sample
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ZERO_LEN  = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;

	// Start code that replaces every length prefix, first byte first
	localparam logic [7:0] START_CODE [BurstMax] = '{8'h00, 8'h00, 8'h00, 8'h01};

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_packet;
		logic       key_frame;
		logic [1:0] status;
	} res_t;

	// Burst of results from one input byte, slot 0 goes out first
	typedef struct packed {
		logic [2:0]    n;
		res_t [3:0]    r;
	} burst_t;

	// Build one result; key and status only carry meaning on the final one
	function automatic res_t mk_res(input logic [7:0] b, input logic valid,
			input logic eop, input logic key, input logic [1:0] st);
		res_t x;
		x.out_byte      = valid ? b : 8'h00;
		x.byte_valid    = valid;
		x.end_of_packet = eop;
		x.key_frame     = eop & key;
		x.status        = eop ? st : ST_OK;
		return x;
	endfunction

	// Window ends in 00 00 01 followed by an IDR NAL header
	function automatic logic win_idr(input logic [31:0] w);
		return (w[31:8] == 24'h000001) && (w[4:0] == NalTypeIdr);
	endfunction

endpackage

`default_nettype wire

// File: design/nlsc_core.sv
// ----------------------------------------------------------------------------
// nlsc_core
// Input register and per-byte conversion step with the sample state.
// ----------------------------------------------------------------------------
`default_nettype none

module nlsc_core import nlsc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       last,
	input  wire logic       can_load,
	output logic            consume,
	output burst_t          burst
);

	typedef enum logic [2:0] {
		PH_HEAD = 3'd0,
		PH_PASS = 3'd1,
		PH_LEN  = 3'd2,
		PH_PAY  = 3'd3,
		PH_ERR  = 3'd4
	} phase_t;

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	phase_t      phase_q, phase_d;
	logic [31:0] win_q, win_d;
	logic [1:0]  fc_q, fc_d;
	logic [31:0] left_q, left_d;
	logic        first_q, first_d;
	logic        key_q, key_d;
	logic [1:0]  err_q, err_d;

	logic [31:0] win_sh;
	logic [31:0] left_dec;
	logic        is_sc;
	logic        key_pay;

	assign consume  = v_s1 & can_load;
	assign in_ready = ~v_s1 | consume;

	// Hold one request until the result buffer has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (consume) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	assign win_sh   = {win_q[23:0], byte_s1};
	assign left_dec = left_q - 32'd1;
	assign is_sc    = (win_sh[31:16] == 16'h0000)
		&& ((win_sh[15:8] == 8'h01) || (win_sh[15:0] == 16'h0001));
	assign key_pay  = key_q | (first_q & (byte_s1[4:0] == NalTypeIdr));

	// Conversion step for the held byte
	always_comb begin
		logic clr;
		logic len_chk;
		logic hdr_chk;
		clr      = 1'b0;
		len_chk  = 1'b0;
		hdr_chk  = 1'b0;
		phase_d  = phase_q;
		win_d    = win_q;
		fc_d     = fc_q;
		left_d   = left_q;
		first_d  = first_q;
		key_d    = key_q;
		err_d    = err_q;
		burst    = '0;

		case (phase_q)
			PH_PASS: begin
				win_d      = win_sh;
				key_d      = key_q | win_idr(win_sh);
				burst.n    = 3'd1;
				burst.r[0] = mk_res(byte_s1, 1'b1, last_s1, key_d, ST_OK);
				clr        = last_s1;
			end
			PH_LEN: begin
				win_d = win_sh;
				if (fc_q != 2'd3) begin
					fc_d = fc_q + 2'd1;
					if (last_s1) begin
						burst.n    = 3'd1;
						burst.r[0] = mk_res(8'h00, 1'b0, 1'b1, key_q, ST_TRUNCATED);
						clr        = 1'b1;
					end
				end else begin
					len_chk = 1'b1;
				end
			end
			PH_PAY: begin
				key_d   = key_pay;
				first_d = 1'b0;
				left_d  = left_dec;
				burst.n = 3'd1;
				if (last_s1) begin
					burst.r[0] = mk_res(byte_s1, 1'b1, 1'b1, key_pay,
						(left_dec == 32'd0) ? ST_OK : ST_TRUNCATED);
					clr = 1'b1;
				end else begin
					burst.r[0] = mk_res(byte_s1, 1'b1, 1'b0, 1'b0, ST_OK);
					if (left_dec == 32'd0) begin
						phase_d = PH_LEN;
						fc_d    = 2'd0;
						win_d   = '0;
					end
				end
			end
			PH_ERR: begin
				if (last_s1) begin
					burst.n    = 3'd1;
					burst.r[0] = mk_res(8'h00, 1'b0, 1'b1, key_q, err_q);
					clr        = 1'b1;
				end
			end
			default: begin
				win_d = win_sh;
				if (fc_q != 2'd3) begin
					fc_d = fc_q + 2'd1;
					if (last_s1) begin
						burst.n    = 3'd1;
						burst.r[0] = mk_res(8'h00, 1'b0, 1'b1, key_q, ST_TRUNCATED);
						clr        = 1'b1;
					end
				end else begin
					hdr_chk = 1'b1;
				end
			end
		endcase

		// Start code in the held header: pass the four bytes through
		if (hdr_chk && is_sc) begin
			key_d   = key_q | win_idr(win_sh);
			burst.n = 3'd4;
			for (int k = 0; k < BurstMax; k++) begin
				burst.r[k] = mk_res(win_sh[31 - 8*k -: 8], 1'b1,
					last_s1 && (k == BurstMax - 1), key_d, ST_OK);
			end
			fc_d    = 2'd0;
			phase_d = PH_PASS;
			clr     = last_s1;
		end else if (hdr_chk) begin
			len_chk = 1'b1;
		end

		// Complete length prefix
		if (len_chk) begin
			if (win_sh == 32'd0) begin
				if (last_s1) begin
					burst.n    = 3'd1;
					burst.r[0] = mk_res(8'h00, 1'b0, 1'b1, key_q, ST_ZERO_LEN);
					clr        = 1'b1;
				end else begin
					err_d   = ST_ZERO_LEN;
					phase_d = PH_ERR;
				end
			end else if (last_s1) begin
				burst.n    = 3'd1;
				burst.r[0] = mk_res(8'h00, 1'b0, 1'b1, key_q, ST_TRUNCATED);
				clr        = 1'b1;
			end else begin
				burst.n = 3'd4;
				for (int k = 0; k < BurstMax; k++) begin
					burst.r[k] = mk_res(START_CODE[k], 1'b1, 1'b0, 1'b0, ST_OK);
				end
				left_d  = win_sh;
				first_d = 1'b1;
				fc_d    = 2'd0;
				phase_d = PH_PAY;
			end
		end

		// Drop all sample state after the final result
		if (clr) begin
			phase_d = PH_HEAD;
			win_d   = '0;
			fc_d    = '0;
			left_d  = '0;
			first_d = 1'b0;
			key_d   = 1'b0;
			err_d   = ST_OK;
		end
	end

	// Advance sample state on each consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			win_q   <= '0;
			fc_q    <= '0;
			left_q  <= '0;
			first_q <= 1'b0;
			key_q   <= 1'b0;
			err_q   <= ST_OK;
		end else if (consume) begin
			phase_q <= phase_d;
			win_q   <= win_d;
			fc_q    <= fc_d;
			left_q  <= left_d;
			first_q <= first_d;
			key_q   <= key_d;
			err_q   <= err_d;
		end
	end

endmodule

`default_nettype wire

// File: design/nlsc_outbuf.sv
// ----------------------------------------------------------------------------
// nlsc_outbuf
// Four-slot result register that loads a whole burst and drains one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module nlsc_outbuf import nlsc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   consume,
	input  wire burst_t burst,
	output logic        can_load,
	output logic        out_valid,
	input  wire logic   out_ready,
	output res_t        out_res
);

	res_t       slot_q [BurstMax];
	logic [2:0] cnt_q;
	logic [1:0] head_q;
	logic       pop;
	logic       load;

	assign out_valid = (cnt_q != 3'd0);
	assign pop       = out_valid & out_ready;
	assign can_load  = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready);
	assign load      = consume && (burst.n != 3'd0);
	assign out_res   = slot_q[head_q];

	// Load a new burst or advance the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			head_q <= '0;
		end else if (load) begin
			cnt_q  <= burst.n;
			head_q <= '0;
		end else if (pop) begin
			cnt_q  <= cnt_q - 3'd1;
			head_q <= head_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < BurstMax; k++) begin
				slot_q[k] <= burst.r[k];
			end
		end
	end

endmodule

`default_nettype wire

// File: design/nal_length_prefix_to_start_code_unit.sv
// ----------------------------------------------------------------------------
// nal_length_prefix_to_start_code_unit
// Converts one H.264 sample from 32-bit length prefixes to start codes.
// ----------------------------------------------------------------------------
// One byte enters per request and is converted in a single registered step:
// a one-byte input register feeds the conversion logic, which loads a
// four-slot result register. Ordinary bytes stream at one per cycle while
// out_ready is high. A byte that completes a length prefix or a start-code
// header yields four results; the input takes one more byte into its
// register and then waits until the last of the four is being taken. Bytes
// held back for a header or length prefix, or swallowed after an error,
// give no result.
`default_nettype none

module nal_length_prefix_to_start_code_unit import nlsc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            end_of_packet,
	output logic            key_frame,
	output logic [1:0]      status
);

	logic   can_load;
	logic   consume;
	burst_t burst;
	res_t   out_res;

	nlsc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.data_byte(data_byte),
		.last     (last),
		.can_load (can_load),
		.consume  (consume),
		.burst    (burst)
	);

	nlsc_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.consume  (consume),
		.burst    (burst),
		.can_load (can_load),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (out_res)
	);

	assign out_byte      = out_res.out_byte;
	assign byte_valid    = out_res.byte_valid;
	assign end_of_packet = out_res.end_of_packet;
	assign key_frame     = out_res.key_frame;
	assign status        = out_res.status;

	// Status-only results close a sample
	a_status_only_eop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> end_of_packet)
		else $error("status-only result without end_of_packet");

	// Error codes and the key flag appear only on the final result
	a_status_on_eop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK || key_frame) |-> end_of_packet)
		else $error("status or key flag on a non-final result");

	// A burst is only loaded once the result register has room
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		consume && burst.n != 3'd0 |-> !out_valid || (out_ready && $past(1'b1)))
		else $error("burst loaded over pending results");

	// A consumed byte with no new one arriving leaves the input register free
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		consume && !in_valid |=> in_ready)
		else $error("input register not freed after consume");

endmodule

`default_nettype wire
